>>> hdl/rmexp_pkg.sv
// rmexp_pkg: types, constants and fixed point helpers of the twist exponential map
// used by the divider, the top level and the simulation files; no dependencies
package rmexp_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [35:0] opnd_t;
  typedef logic signed [41:0] prod_t;

  localparam prod_t ONE_Q30 = 42'sd1073741824;
  localparam prod_t LIM31   = 42'sd2147483647;
  localparam prod_t LIM32   = 42'sd4294967295;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam int DIV_NW = 62;
  localparam int DIV_QW = 32;
  localparam int NUM_DIV = 5;

  // per-item data that rides along the pipeline
  typedef struct packed {
    word_t [2:0]        w;
    word_t [2:0]        v;
    logic [31:0]        theta;
    logic               zero;
    word_t              sn;
    logic signed [32:0] b;
    word_t [2:0]        k;
    word_t              f1;
    word_t              f2;
  } side_t;

  // arctangent of 2^-i in q.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'd843314857;
      1: a = 32'd497837829;
      2: a = 32'd263043837;
      3: a = 32'd133525159;
      4: a = 32'd67021687;
      5: a = 32'd33543516;
      6: a = 32'd16775851;
      7: a = 32'd8388437;
      8: a = 32'd4194283;
      9: a = 32'd2097149;
      default: a = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return a;
  endfunction

  // q30 product, rounded, shift floors
  function automatic prod_t mulq30(input opnd_t a, input opnd_t b);
    logic signed [71:0] p;
    p = a * b;
    p = p + 72'sd536870912;
    return prod_t'(p >>> 30);
  endfunction

  function automatic prod_t clampv(input prod_t v, input prod_t lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic word_t sat32(input prod_t v);
    if (v > 42'sd2147483647) return 32'sh7fffffff;
    if (v < -42'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input word_t x);
    logic [31:0] u;
    u = x;
    return u[31] ? (~u + 32'd1) : u;
  endfunction

  function automatic opnd_t opw(input word_t x);
    return opnd_t'(x);
  endfunction

endpackage

>>> hdl/rmexp_if.sv
// rmexp_in_if / rmexp_out_if: valid-ready channels for twists and rigid motions
// payload fields are plain signed words; no dependencies
interface rmexp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic signed [31:0] lin_x;
  logic signed [31:0] lin_y;
  logic signed [31:0] lin_z;

  modport source (output valid, rot_x, rot_y, rot_z, lin_x, lin_y, lin_z, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, lin_x, lin_y, lin_z, output ready);
endinterface

interface rmexp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_row1_col1;
  logic signed [31:0] r_row1_col2;
  logic signed [31:0] r_row1_col3;
  logic signed [31:0] r_row2_col1;
  logic signed [31:0] r_row2_col2;
  logic signed [31:0] r_row2_col3;
  logic signed [31:0] r_row3_col1;
  logic signed [31:0] r_row3_col2;
  logic signed [31:0] r_row3_col3;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, r_row1_col1, r_row1_col2, r_row1_col3, r_row2_col1,
                  r_row2_col2, r_row2_col3, r_row3_col1, r_row3_col2, r_row3_col3,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, r_row1_col1, r_row1_col2, r_row1_col3, r_row2_col1,
                r_row2_col2, r_row2_col3, r_row3_col1, r_row3_col2, r_row3_col3,
                pos_x, pos_y, pos_z, output ready);
endinterface

>>> hdl/rigid_motion_exponential.sv
// rigid_motion_exponential: twist to rotation matrix and position, fully pipelined
// throughput one twist per cycle; a stalled output freezes the whole pipeline
// the root takes 32 stages, the divider 33 and the CORDIC one stage per iteration
// reset clears the valid bits only; data registers are not reset
module rigid_motion_exponential #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  rmexp_in_if.sink         in_ch,
  rmexp_out_if.source      out_ch
);
  import rmexp_pkg::*;

  localparam int N      = CORDIC_STAGES;
  localparam int IDX_TH = 34;
  localparam int IDX_C1 = 37 + N;
  localparam int IDX_F  = 71 + N;
  localparam int LAT    = 78 + N;
  localparam int SD_LEN = IDX_F + 6;

  logic           adv;
  logic [LAT-1:0] vld_r;
  side_t          sd_r   [SD_LEN];
  side_t          sd_nxt [SD_LEN];
  side_t          sd_in;

  logic [63:0] sq_r [3];
  logic [63:0] sum_r;
  logic [63:0] qn_r [32];
  logic [63:0] qr_r [32];

  logic signed [34:0] z1_r, z2_r, z3_r;
  logic               neg3_r;
  logic signed [34:0] t4;

  logic signed [33:0] cx_r [N];
  logic signed [33:0] cy_r [N];
  logic signed [34:0] cz_r [N];
  logic               cn_r [N];

  logic [DIV_NW-1:0] dnum [NUM_DIV];
  logic [DIV_QW:0]   dq   [NUM_DIV];

  prod_t c_nxt, s_nxt, b_nxt;
  word_t [2:0] k_nxt;
  prod_t tk, f2t;

  prod_t p1_kk_r [6];
  prod_t p1_mk_r [6];
  prod_t p1_sk_r [3];
  logic signed [33:0] p2_m_r [3];
  prod_t p2_ks_r [3];
  prod_t p2_kc_r [3];
  prod_t p2_sk_r [3];
  prod_t p3_nk_r [6];
  prod_t p3_bs_r [3];
  prod_t p3_bc_r [3];
  prod_t p3_sk_r [3];
  prod_t p3_fm_r [3];
  logic signed [33:0] p4_n_r [3];
  word_t p4_rm_r [9];
  prod_t p4_fm_r [3];
  prod_t p5_f2n_r [3];
  prod_t p5_acc_r [3];
  word_t p5_rm_r [9];
  word_t o_rm_r [9];
  word_t o_pos_r [3];

  // global advance: every stage moves unless a result waits on a stalled sink
  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // side data of the incoming beat
  always_comb begin
    sd_in      = '0;
    sd_in.w[0] = in_ch.rot_x;
    sd_in.w[1] = in_ch.rot_y;
    sd_in.w[2] = in_ch.rot_z;
    sd_in.v[0] = in_ch.lin_x;
    sd_in.v[1] = in_ch.lin_y;
    sd_in.v[2] = in_ch.lin_z;
  end

  // squares and their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= 64'(mag32(in_ch.rot_x)) * 64'(mag32(in_ch.rot_x));
      sq_r[1] <= 64'(mag32(in_ch.rot_y)) * 64'(mag32(in_ch.rot_y));
      sq_r[2] <= 64'(mag32(in_ch.rot_z)) * 64'(mag32(in_ch.rot_z));
      sum_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // integer square root, two radicand bits per stage
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [63:0] SQB = 64'd1 << (62 - 2 * j);
    logic [63:0] n_in, r_in, n_nxt, r_nxt;
    logic [64:0] t;
    if (j == 0) begin : g_first
      assign n_in = sum_r;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = qn_r[j-1];
      assign r_in = qr_r[j-1];
    end
    always_comb begin
      t = {1'b0, r_in} + {1'b0, SQB};
      if ({1'b0, n_in} >= t) begin
        n_nxt = n_in - t[63:0];
        r_nxt = (r_in >> 1) + SQB;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        qn_r[j] <= n_nxt;
        qr_r[j] <= r_nxt;
      end
    end
  end

  // angle reduction: modulo two pi, then fold into the right half plane
  assign t4 = $signed({1'b0, qr_r[31][31:0], 2'b00});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (t4 >= 2 * TWO_PI_Q30) begin
        z1_r <= t4 - 2 * TWO_PI_Q30;
      end else if (t4 >= TWO_PI_Q30) begin
        z1_r <= t4 - TWO_PI_Q30;
      end else begin
        z1_r <= t4;
      end
      z2_r <= (z1_r > PI_Q30) ? z1_r - TWO_PI_Q30 : z1_r;
      if (z2_r > HALF_PI_Q30) begin
        z3_r   <= PI_Q30 - z2_r;
        neg3_r <= 1'b1;
      end else if (z2_r < -HALF_PI_Q30) begin
        z3_r   <= -PI_Q30 - z2_r;
        neg3_r <= 1'b1;
      end else begin
        z3_r   <= z2_r;
        neg3_r <= 1'b0;
      end
    end
  end

  // cordic rotation, one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [34:0] AT = $signed({3'b000, atan_q30(i)});
    logic signed [33:0] x_in, y_in;
    logic signed [34:0] z_in;
    logic               n_in;
    if (i == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z3_r;
      assign n_in = neg3_r;
    end else begin : g_next
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign z_in = cz_r[i-1];
      assign n_in = cn_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cn_r[i] <= n_in;
        if (z_in >= 0) begin
          cx_r[i] <= x_in - (y_in >>> i);
          cy_r[i] <= y_in + (x_in >>> i);
          cz_r[i] <= z_in - AT;
        end else begin
          cx_r[i] <= x_in + (y_in >>> i);
          cy_r[i] <= y_in - (x_in >>> i);
          cz_r[i] <= z_in + AT;
        end
      end
    end
  end

  // sine, cosine and one minus cosine
  always_comb begin
    c_nxt = clampv(cn_r[N-1] ? -prod_t'(cx_r[N-1]) : prod_t'(cx_r[N-1]), ONE_Q30);
    s_nxt = clampv(prod_t'(cy_r[N-1]), ONE_Q30);
    b_nxt = ONE_Q30 - c_nxt;
  end

  // divider operands: k components, f1 and f2 over theta
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dnum[i] = {mag32(sd_r[IDX_C1].w[i]), 30'b0};
    end
    dnum[3] = {2'b00, sd_r[IDX_C1].b[31:0], 28'b0};
    dnum[4] = {2'b00, mag32(sd_r[IDX_C1].sn), 28'b0};
  end

  for (genvar d = 0; d < NUM_DIV; d++) begin : g_div
    rmexp_div u_div (
      .clk (clk),
      .en  (adv),
      .num (dnum[d]),
      .den (sd_r[IDX_C1].theta),
      .quo (dq[d])
    );
  end

  // signed quotients, clamped
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      tk = prod_t'(dq[i]);
      if (sd_r[IDX_F-1].w[i][31]) begin
        tk = -tk;
      end
      k_nxt[i] = word_t'(clampv(tk, ONE_Q30));
    end
    f2t = sd_r[IDX_F-1].sn[31] ? ONE_Q30 + prod_t'(dq[4]) : ONE_Q30 - prod_t'(dq[4]);
  end

  // side line with the values that appear along the way
  always_comb begin
    sd_nxt[0] = sd_in;
    for (int i = 1; i < SD_LEN; i++) begin
      sd_nxt[i] = sd_r[i-1];
    end
    sd_nxt[IDX_TH].theta = qr_r[31][31:0];
    sd_nxt[IDX_TH].zero  = (qr_r[31] == 64'd0);
    sd_nxt[IDX_C1].sn    = s_nxt[31:0];
    sd_nxt[IDX_C1].b     = b_nxt[32:0];
    sd_nxt[IDX_F].k      = k_nxt;
    sd_nxt[IDX_F].f1     = (prod_t'(dq[3]) > LIM31) ? LIM31[31:0] : dq[3][31:0];
    sd_nxt[IDX_F].f2     = word_t'(clampv(f2t, LIM31));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SD_LEN; i++) begin
        sd_r[i] <= sd_nxt[i];
      end
    end
  end

  // products of k with itself, with v and with the sine
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kk_r[0] <= mulq30(opw(sd_r[IDX_F].k[0]), opw(sd_r[IDX_F].k[0]));
      p1_kk_r[1] <= mulq30(opw(sd_r[IDX_F].k[1]), opw(sd_r[IDX_F].k[1]));
      p1_kk_r[2] <= mulq30(opw(sd_r[IDX_F].k[2]), opw(sd_r[IDX_F].k[2]));
      p1_kk_r[3] <= mulq30(opw(sd_r[IDX_F].k[0]), opw(sd_r[IDX_F].k[1]));
      p1_kk_r[4] <= mulq30(opw(sd_r[IDX_F].k[0]), opw(sd_r[IDX_F].k[2]));
      p1_kk_r[5] <= mulq30(opw(sd_r[IDX_F].k[1]), opw(sd_r[IDX_F].k[2]));
      p1_mk_r[0] <= mulq30(opw(sd_r[IDX_F].k[1]), opw(sd_r[IDX_F].v[2]));
      p1_mk_r[1] <= mulq30(opw(sd_r[IDX_F].k[2]), opw(sd_r[IDX_F].v[1]));
      p1_mk_r[2] <= mulq30(opw(sd_r[IDX_F].k[2]), opw(sd_r[IDX_F].v[0]));
      p1_mk_r[3] <= mulq30(opw(sd_r[IDX_F].k[0]), opw(sd_r[IDX_F].v[2]));
      p1_mk_r[4] <= mulq30(opw(sd_r[IDX_F].k[0]), opw(sd_r[IDX_F].v[1]));
      p1_mk_r[5] <= mulq30(opw(sd_r[IDX_F].k[1]), opw(sd_r[IDX_F].v[0]));
      for (int i = 0; i < 3; i++) begin
        p1_sk_r[i] <= mulq30(opw(sd_r[IDX_F].sn), opw(sd_r[IDX_F].k[i]));
      end
    end
  end

  // m = k cross v, and the sums of squares of k
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_m_r[0]  <= 34'(clampv(p1_mk_r[0] - p1_mk_r[1], LIM32));
      p2_m_r[1]  <= 34'(clampv(p1_mk_r[2] - p1_mk_r[3], LIM32));
      p2_m_r[2]  <= 34'(clampv(p1_mk_r[4] - p1_mk_r[5], LIM32));
      p2_ks_r[0] <= p1_kk_r[1] + p1_kk_r[2];
      p2_ks_r[1] <= p1_kk_r[2] + p1_kk_r[0];
      p2_ks_r[2] <= p1_kk_r[0] + p1_kk_r[1];
      for (int i = 0; i < 3; i++) begin
        p2_kc_r[i] <= p1_kk_r[3+i];
        p2_sk_r[i] <= p1_sk_r[i];
      end
    end
  end

  // k cross m, the rotation products and f1 times m
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_nk_r[0] <= mulq30(opw(sd_r[IDX_F+2].k[1]), opnd_t'(p2_m_r[2]));
      p3_nk_r[1] <= mulq30(opw(sd_r[IDX_F+2].k[2]), opnd_t'(p2_m_r[1]));
      p3_nk_r[2] <= mulq30(opw(sd_r[IDX_F+2].k[2]), opnd_t'(p2_m_r[0]));
      p3_nk_r[3] <= mulq30(opw(sd_r[IDX_F+2].k[0]), opnd_t'(p2_m_r[2]));
      p3_nk_r[4] <= mulq30(opw(sd_r[IDX_F+2].k[0]), opnd_t'(p2_m_r[1]));
      p3_nk_r[5] <= mulq30(opw(sd_r[IDX_F+2].k[1]), opnd_t'(p2_m_r[0]));
      for (int i = 0; i < 3; i++) begin
        p3_bs_r[i] <= mulq30(opnd_t'(sd_r[IDX_F+2].b), opnd_t'(p2_ks_r[i]));
        p3_bc_r[i] <= mulq30(opnd_t'(sd_r[IDX_F+2].b), opnd_t'(p2_kc_r[i]));
        p3_sk_r[i] <= p2_sk_r[i];
        p3_fm_r[i] <= mulq30(opw(sd_r[IDX_F+2].f1), opnd_t'(p2_m_r[i]));
      end
    end
  end

  // n = k cross m, rotation entries; identity when theta is zero
  always_ff @(posedge clk) begin
    if (adv) begin
      p4_n_r[0] <= 34'(clampv(p3_nk_r[0] - p3_nk_r[1], LIM32));
      p4_n_r[1] <= 34'(clampv(p3_nk_r[2] - p3_nk_r[3], LIM32));
      p4_n_r[2] <= 34'(clampv(p3_nk_r[4] - p3_nk_r[5], LIM32));
      for (int i = 0; i < 3; i++) begin
        p4_fm_r[i] <= p3_fm_r[i];
      end
      if (sd_r[IDX_F+3].zero) begin
        for (int i = 0; i < 9; i++) begin
          p4_rm_r[i] <= (i % 4 == 0) ? ONE_Q30[31:0] : 32'sd0;
        end
      end else begin
        p4_rm_r[0] <= sat32(ONE_Q30 - p3_bs_r[0]);
        p4_rm_r[1] <= sat32(p3_bc_r[0] - p3_sk_r[2]);
        p4_rm_r[2] <= sat32(p3_bc_r[1] + p3_sk_r[1]);
        p4_rm_r[3] <= sat32(p3_bc_r[0] + p3_sk_r[2]);
        p4_rm_r[4] <= sat32(ONE_Q30 - p3_bs_r[1]);
        p4_rm_r[5] <= sat32(p3_bc_r[2] - p3_sk_r[0]);
        p4_rm_r[6] <= sat32(p3_bc_r[1] - p3_sk_r[1]);
        p4_rm_r[7] <= sat32(p3_bc_r[2] + p3_sk_r[0]);
        p4_rm_r[8] <= sat32(ONE_Q30 - p3_bs_r[2]);
      end
    end
  end

  // f2 times n, partial position
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p5_f2n_r[i] <= mulq30(opw(sd_r[IDX_F+4].f2), opnd_t'(p4_n_r[i]));
        p5_acc_r[i] <= prod_t'(sd_r[IDX_F+4].v[i]) + p4_fm_r[i];
      end
      for (int i = 0; i < 9; i++) begin
        p5_rm_r[i] <= p4_rm_r[i];
      end
    end
  end

  // output register; position is v exactly when theta is zero
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_pos_r[i] <= sd_r[IDX_F+5].zero ? sd_r[IDX_F+5].v[i]
                                          : sat32(p5_acc_r[i] + p5_f2n_r[i]);
      end
      for (int i = 0; i < 9; i++) begin
        o_rm_r[i] <= p5_rm_r[i];
      end
    end
  end

  assign out_ch.valid       = vld_r[LAT-1];
  assign out_ch.r_row1_col1 = o_rm_r[0];
  assign out_ch.r_row1_col2 = o_rm_r[1];
  assign out_ch.r_row1_col3 = o_rm_r[2];
  assign out_ch.r_row2_col1 = o_rm_r[3];
  assign out_ch.r_row2_col2 = o_rm_r[4];
  assign out_ch.r_row2_col3 = o_rm_r[5];
  assign out_ch.r_row3_col1 = o_rm_r[6];
  assign out_ch.r_row3_col2 = o_rm_r[7];
  assign out_ch.r_row3_col3 = o_rm_r[8];
  assign out_ch.pos_x       = o_pos_r[0];
  assign out_ch.pos_y       = o_pos_r[1];
  assign out_ch.pos_z       = o_pos_r[2];

endmodule

>>> hdl/rmexp_div.sv
// rmexp_div: pipelined restoring divider, rounded quotient saturating at 2^32
// one quotient bit per stage, 33 register stages; uses rmexp_pkg
module rmexp_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rmexp_pkg::DIV_NW-1:0]     num,
  input  logic [rmexp_pkg::DIV_QW-1:0]     den,
  output logic [rmexp_pkg::DIV_QW:0]       quo
);
  import rmexp_pkg::*;

  logic [63:0]       rem_r [DIV_QW+1];
  logic [DIV_QW-1:0] den_r [DIV_QW+1];
  logic [DIV_QW-1:0] q_r   [DIV_QW+1];
  logic              ovf_r [DIV_QW+1];

  // rounding offset and overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 64'(num) + 64'(den >> 1);
      ovf_r[0] <= ((64'(num) + 64'(den >> 1)) >> DIV_QW) >= 64'(den);
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j <= DIV_QW; j++) begin : g_bit
    localparam int BP = DIV_QW - j;
    logic [63:0] trial;
    assign trial = 64'(den_r[j-1]) << BP;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        if (rem_r[j-1] >= trial) begin
          rem_r[j] <= rem_r[j-1] - trial;
          q_r[j]   <= q_r[j-1] | (DIV_QW'(1) << BP);
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  assign quo = ovf_r[DIV_QW] ? ((DIV_QW+1)'(1) << DIV_QW) : {1'b0, q_r[DIV_QW]};

endmodule

>>> sim/rmexp_checker.sv
`timescale 1ns / 1ps
// rmexp_checker: watches the twist and rigid motion channels, predicts each motion
// and compares it field by field; depends on rmexp_pkg and rmexp_if.sv
module rmexp_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  rmexp_in_if         in_ch,
  rmexp_out_if        out_ch,
  output int          fail_count,
  output int          pending
);
  import rmexp_pkg::*;

  typedef logic signed [63:0] s64_t;

  typedef struct {
    s64_t rmat [9];
    s64_t pos  [3];
  } motion_t;

  motion_t motion_q[$];

  localparam s64_t Q30_ONE  = 64'sd1073741824;
  localparam s64_t Q30_PI   = 64'sd3373259426;
  localparam s64_t Q30_HPI  = 64'sd1686629713;
  localparam s64_t Q30_2PI  = 64'sd6746518852;
  localparam s64_t GAIN0    = 64'sd652032874;
  localparam s64_t MAX31    = 64'sd2147483647;
  localparam s64_t MAX32    = 64'sd4294967295;

  function automatic s64_t arc_tan(input int i);
    s64_t tbl [10];
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return s64_t'(1) <<< (30 - i);
    return 0;
  endfunction

  function automatic s64_t lim(input s64_t v, input s64_t l);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic s64_t sat(input s64_t v);
    if (v > MAX31) return MAX31;
    if (v < -MAX31 - 1) return -MAX31 - 1;
    return v;
  endfunction

  function automatic s64_t qmul(input s64_t a, input s64_t b);
    return (a * b + (s64_t'(1) <<< 29)) >>> 30;
  endfunction

  // rounded division, half away from zero
  function automatic s64_t rdiv(input s64_t num, input int sh, input logic [63:0] den);
    logic [63:0] m, q;
    m = (num < 0) ? 64'(-num) : 64'(num);
    q = ((m << sh) + den / 2) / den;
    return (num < 0) ? -s64_t'(q) : s64_t'(q);
  endfunction

  function automatic logic [63:0] root(input logic [63:0] n);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic void cross3(input s64_t k [3], input s64_t u [3], output s64_t o [3]);
    o[0] = lim(qmul(k[1], u[2]) - qmul(k[2], u[1]), MAX32);
    o[1] = lim(qmul(k[2], u[0]) - qmul(k[0], u[2]), MAX32);
    o[2] = lim(qmul(k[0], u[1]) - qmul(k[1], u[0]), MAX32);
  endfunction

  function automatic motion_t predict_motion(input s64_t w [3], input s64_t v [3]);
    motion_t mo;
    logic [63:0] sum, th, mg;
    s64_t k [3];
    s64_t m [3];
    s64_t n [3];
    s64_t z, x, y, nx, sn, cs, b, f1, f2, k11, k22, k33, k12, k13, k23;
    logic neg;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mg = (w[i] < 0) ? 64'(-w[i]) : 64'(w[i]);
      sum += mg * mg;
    end
    th = root(sum);
    if (th == 0) begin
      for (int i = 0; i < 9; i++) mo.rmat[i] = (i % 4 == 0) ? Q30_ONE : 0;
      for (int i = 0; i < 3; i++) mo.pos[i] = v[i];
      return mo;
    end
    for (int i = 0; i < 3; i++) k[i] = lim(rdiv(w[i], 30, th), Q30_ONE);
    // cordic rotation after reduction into the right half plane
    z = s64_t'((th * 4) % 64'(Q30_2PI));
    neg = 0;
    if (z > Q30_PI) z -= Q30_2PI;
    if (z > Q30_HPI) begin
      z = Q30_PI - z;
      neg = 1;
    end else if (z < -Q30_HPI) begin
      z = -Q30_PI - z;
      neg = 1;
    end
    x = GAIN0;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_tan(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_tan(i);
      end
      x = nx;
    end
    cs = lim(neg ? -x : x, Q30_ONE);
    sn = lim(y, Q30_ONE);
    b = Q30_ONE - cs;
    k11 = qmul(k[0], k[0]); k22 = qmul(k[1], k[1]); k33 = qmul(k[2], k[2]);
    k12 = qmul(k[0], k[1]); k13 = qmul(k[0], k[2]); k23 = qmul(k[1], k[2]);
    mo.rmat[0] = Q30_ONE - qmul(b, k22 + k33);
    mo.rmat[1] = qmul(b, k12) - qmul(sn, k[2]);
    mo.rmat[2] = qmul(b, k13) + qmul(sn, k[1]);
    mo.rmat[3] = qmul(b, k12) + qmul(sn, k[2]);
    mo.rmat[4] = Q30_ONE - qmul(b, k33 + k11);
    mo.rmat[5] = qmul(b, k23) - qmul(sn, k[0]);
    mo.rmat[6] = qmul(b, k13) - qmul(sn, k[1]);
    mo.rmat[7] = qmul(b, k23) + qmul(sn, k[0]);
    mo.rmat[8] = Q30_ONE - qmul(b, k11 + k22);
    f1 = lim(rdiv(b, 28, th), MAX31);
    f2 = lim(Q30_ONE - rdiv(sn, 28, th), MAX31);
    cross3(k, v, m);
    cross3(k, m, n);
    for (int i = 0; i < 3; i++) mo.pos[i] = v[i] + qmul(f1, m[i]) + qmul(f2, n[i]);
    for (int i = 0; i < 9; i++) mo.rmat[i] = sat(mo.rmat[i]);
    for (int i = 0; i < 3; i++) mo.pos[i] = sat(mo.pos[i]);
    return mo;
  endfunction

  // predict on every twist beat, compare on every motion beat
  always @(posedge clk) begin
    s64_t w [3];
    s64_t v [3];
    s64_t got [12];
    motion_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        w = '{in_ch.rot_x, in_ch.rot_y, in_ch.rot_z};
        v = '{in_ch.lin_x, in_ch.lin_y, in_ch.lin_z};
        motion_q.insert(motion_q.size(), predict_motion(w, v));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.r_row1_col1, out_ch.r_row1_col2, out_ch.r_row1_col3,
                out_ch.r_row2_col1, out_ch.r_row2_col2, out_ch.r_row2_col3,
                out_ch.r_row3_col1, out_ch.r_row3_col2, out_ch.r_row3_col3,
                out_ch.pos_x, out_ch.pos_y, out_ch.pos_z};
        if (motion_q.size() == 0) begin
          $display("%0t: unexpected motion beat, r11 %0d", $time, got[0]);
          errs++;
        end else begin
          want = motion_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (got[i] != (i < 9 ? want.rmat[i] : want.pos[i - 9])) begin
              $display("%0t: field %0d expected %0d actual %0d", $time, i,
                       (i < 9 ? want.rmat[i] : want.pos[i - 9]), got[i]);
              errs++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= motion_q.size();
    end
  end

endmodule

>>> sim/rigid_motion_exponential_tb.sv
`timescale 1ns / 1ps
// rigid_motion_exponential_tb: drives twists with random gaps and output stalls,
// checking is done by rmexp_checker; depends on rmexp_pkg, rmexp_if.sv and the rtl
module rigid_motion_exponential_tb;
  import rmexp_pkg::*;

  localparam int NUM_RANDOM = 2000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;

  rmexp_in_if  in_ch ();
  rmexp_out_if out_ch ();

  rigid_motion_exponential uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rmexp_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                     .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 8)) - 4;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($signed($urandom) >>> $urandom_range(0, 24));
    endcase
  endfunction

  // send one twist beat, holding until accepted; valid stays high across back to back beats
  task automatic send_twist(input word_t wx, wy, wz, vx, vy, vz);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.rot_x <= wx; in_ch.rot_y <= wy; in_ch.rot_z <= wz;
    in_ch.lin_x <= vx; in_ch.lin_y <= vy; in_ch.lin_z <= vz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // random output stalls, with occasional stretches of none
  initial begin
    int stall;
    out_ch.ready <= 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  initial begin
    word_t mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    rst_n = 0;
    in_ch.valid = 0;
    {in_ch.rot_x, in_ch.rot_y, in_ch.rot_z} = '0;
    {in_ch.lin_x, in_ch.lin_y, in_ch.lin_z} = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // zero rotation, tiny rotations, extreme angles and translations
    send_twist(0, 0, 0, 0, 0, 0);
    send_twist(0, 0, 0, mx, mn, 12345);
    send_twist(1, 0, 0, mx, mx, mx);
    send_twist(0, -1, 0, mn, mn, mn);
    send_twist(0, 0, 2, 65536, -65536, 1);
    send_twist(1, 1, 1, mx, mn, mx);
    send_twist(mx, mx, mx, mx, mx, mx);
    send_twist(mn, mn, mn, mn, mn, mn);
    send_twist(mx, 0, 0, 65536, 65536, 65536);
    send_twist(mn, 0, 0, -65536, 0, 65536);
    send_twist(0, 32'sd843314857, 0, 1 << 20, 0, 0);
    send_twist(0, 0, 32'sd421657428, 0, 1 << 20, 0);
    send_twist(32'sd843314857 * 2, 0, 0, 0, 0, 1 << 20);
    send_twist(-32'sd1686629713, 0, 0, mx, 0, mn);
    send_twist(32'sd100000, -32'sd200000, 32'sd300000, 7, -7, 3);
    send_twist(mx, mn, 0, -1, -1, -1);
    for (int i = 0; i < NUM_RANDOM; i++)
      send_twist(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    in_ch.valid <= 0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
